// ----- hdl/hrlc_pkg.sv -----
// Shared types and constants for the request line checker.
// Holds the transfer payload structs, status and method codes and match tables.
// No dependencies.
`default_nettype none

package hrlc_pkg;

    // verdict codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_VERSION  = 3'd3;
    localparam logic [2:0] ST_METHOD   = 3'd4;

    // method codes
    localparam logic [1:0] METH_GET    = 2'd0;
    localparam logic [1:0] METH_POST   = 2'd1;
    localparam logic [1:0] METH_DELETE = 2'd2;

    // register map
    localparam logic [1:0] REG_MAX_LINE_LENGTH = 2'd0;
    localparam logic [15:0] MAX_LINE_LENGTH_RST = 16'd8000;

    // special bytes
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    // method names, zero padded to eight characters
    localparam logic [7:0] METH_NAME [3][8] = '{
        '{"G", "E", "T", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"P", "O", "S", "T", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"D", "E", "L", "E", "T", "E", 8'd0, 8'd0}
    };
    localparam logic [15:0] METH_LEN [3] = '{16'd3, 16'd4, 16'd6};

    // version strings, bit 0 of the mask is HTTP/1.1, bit 1 is HTTP/1.0
    localparam logic [7:0] VER_NAME [2][8] = '{
        '{"H", "T", "T", "P", "/", "1", ".", "1"},
        '{"H", "T", "T", "P", "/", "1", ".", "0"}
    };
    localparam logic [15:0] VER_LEN = 16'd8;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       byte_present;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  method_code;
        logic        version_minor;
        logic [15:0] uri_start;
        logic [15:0] uri_length;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hdl/hrlc_line_track.sv -----
// Per-line tracking state of the request line checker and the verdict logic.
// Updates counters and match masks from one byte and forms the verdict at end of line.
// Depends on hrlc_pkg.
`default_nettype none

module hrlc_line_track #(
    parameter int COUNT_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  hrlc_pkg::t_in_item   i_item,
    input  wire [15:0]           i_max_len,
    output logic                 o_result_valid,
    output hrlc_pkg::t_out_item  o_result
);
    import hrlc_pkg::*;

    logic [COUNT_BITS-1:0] r_byte_count, n_byte_count;
    logic                  r_overflow, n_overflow;
    logic [1:0]            r_space_count, n_space_count;
    logic                  r_prev_space, n_prev_space;
    logic                  r_malformed, n_malformed;
    logic [15:0]           r_field_pos, n_field_pos;
    logic [2:0]            r_meth_mask, n_meth_mask;
    logic [1:0]            r_ver_mask, n_ver_mask;
    logic [15:0]           r_uri_begin, n_uri_begin;
    logic [15:0]           r_uri_bytes, n_uri_bytes;

    logic                  w_byte;
    logic                  w_first;
    logic                  w_count_sat;
    logic [COUNT_BITS-1:0] w_count_inc;
    logic [COUNT_BITS+15:0] w_count_ext;
    logic [1:0]            w_ver_mask;
    logic                  w_too_long;
    logic [7:0]            w_b;

    assign w_byte      = i_step && i_item.byte_present;
    assign w_b         = i_item.line_byte;
    assign w_first     = (r_byte_count == '0) && !r_overflow;
    assign w_count_sat = (r_byte_count == '1);
    assign w_count_inc = w_count_sat ? r_byte_count : r_byte_count + 1'b1;
    assign w_count_ext = {16'b0, w_count_inc};

    // state update for one byte of the line
    always_comb begin
        n_byte_count  = r_byte_count;
        n_overflow    = r_overflow;
        n_space_count = r_space_count;
        n_prev_space  = r_prev_space;
        n_malformed   = r_malformed;
        n_field_pos   = r_field_pos;
        n_meth_mask   = r_meth_mask;
        n_ver_mask    = r_ver_mask;
        n_uri_begin   = r_uri_begin;
        n_uri_bytes   = r_uri_bytes;
        if (w_byte) begin
            n_byte_count = w_count_inc;
            if (w_count_sat) begin
                n_overflow = 1'b1;
            end
            if (w_b == CHAR_TAB) begin
                n_malformed = 1'b1;
            end
            if (w_b == CHAR_SPACE) begin
                if (w_first || r_prev_space) begin
                    n_malformed = 1'b1;
                end
                // first space closes the method field
                if (r_space_count == 2'd0) begin
                    for (int k = 0; k < 3; k++) begin
                        if (METH_LEN[k] != r_field_pos) begin
                            n_meth_mask[k] = 1'b0;
                        end
                    end
                    n_uri_begin = w_count_ext[15:0];
                end
                if (r_space_count != 2'd3) begin
                    n_space_count = r_space_count + 2'd1;
                end
                n_field_pos  = '0;
                n_prev_space = 1'b1;
            end else begin
                unique case (r_space_count)
                    2'd0: begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_field_pos >= METH_LEN[k] ||
                                METH_NAME[k][r_field_pos[2:0]] != w_b) begin
                                n_meth_mask[k] = 1'b0;
                            end
                        end
                    end
                    2'd1: begin
                        if (r_uri_bytes != 16'hFFFF) begin
                            n_uri_bytes = r_uri_bytes + 16'd1;
                        end
                    end
                    2'd2: begin
                        for (int k = 0; k < 2; k++) begin
                            if (r_field_pos >= VER_LEN ||
                                VER_NAME[k][r_field_pos[2:0]] != w_b) begin
                                n_ver_mask[k] = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_field_pos != 16'hFFFF) begin
                    n_field_pos = r_field_pos + 16'd1;
                end
                n_prev_space = 1'b0;
            end
        end
    end

    // ranked verdict over the updated state
    assign w_ver_mask = (n_field_pos == VER_LEN) ? n_ver_mask : 2'b00;
    assign w_too_long = n_overflow ||
                        ({16'b0, n_byte_count} > {{COUNT_BITS{1'b0}}, i_max_len});

    always_comb begin
        o_result = '0;
        priority if (w_too_long) begin
            o_result.status = ST_TOO_LONG;
        end else if (n_byte_count == '0 || n_malformed || n_prev_space ||
                     n_space_count != 2'd2) begin
            o_result.status = ST_BAD;
        end else if (w_ver_mask == 2'b00) begin
            o_result.status = ST_VERSION;
        end else if (n_meth_mask == 3'b000) begin
            o_result.status = ST_METHOD;
        end else begin
            o_result.status        = ST_OK;
            o_result.method_code   = n_meth_mask[0] ? METH_GET :
                                     (n_meth_mask[1] ? METH_POST : METH_DELETE);
            o_result.version_minor = w_ver_mask[0];
            o_result.uri_start     = n_uri_begin;
            o_result.uri_length    = n_uri_bytes;
        end
    end

    assign o_result_valid = i_step && i_item.end_of_line;

    // line state registers, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_result_valid) begin
            r_byte_count  <= '0;
            r_overflow    <= 1'b0;
            r_space_count <= 2'd0;
            r_prev_space  <= 1'b0;
            r_malformed   <= 1'b0;
            r_field_pos   <= '0;
            r_meth_mask   <= 3'b111;
            r_ver_mask    <= 2'b11;
            r_uri_begin   <= '0;
            r_uri_bytes   <= '0;
        end else begin
            r_byte_count  <= n_byte_count;
            r_overflow    <= n_overflow;
            r_space_count <= n_space_count;
            r_prev_space  <= n_prev_space;
            r_malformed   <= n_malformed;
            r_field_pos   <= n_field_pos;
            r_meth_mask   <= n_meth_mask;
            r_ver_mask    <= n_ver_mask;
            r_uri_begin   <= n_uri_begin;
            r_uri_bytes   <= n_uri_bytes;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hrlc_out_stage.sv -----
// Result register of the request line checker with valid and stall handshake.
// Holds one verdict until the receiver takes the transfer.
// Depends on hrlc_pkg.
`default_nettype none

module hrlc_out_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  hrlc_pkg::t_out_item  i_data,
    output logic                 o_can_load,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output hrlc_pkg::t_out_item  o_out_data
);
    import hrlc_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    // slot is free when empty or when the held result leaves this cycle
    assign o_can_load = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && i_out_stall);
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

// ----- hdl/http_request_line_checker_core.sv -----
// Request line checker: takes a request line one byte per transfer and gives one verdict.
// Bytes enter the input register, the verdict leaves the result register.
// Depends on hrlc_pkg, hrlc_line_track and hrlc_out_stage.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_data) carries one byte per transfer,
//   with byte_present and end_of_line flags. A transfer with end_of_line closes the
//   line and produces exactly one result on the output channel
//   (o_out_valid, i_out_stall, o_out_data); other transfers produce none.
//   Throughput is one input transfer per cycle while the input does not stall. A
//   verdict appears on the output from the result register: the byte checks and ranking
//   run on the input register and load the result register once the closing transfer advances.
//   If the receiver stalls, the result register holds; byte transfers still pass
//   through the line state, and the input stalls only while a closing transfer
//   waits for the result register to free up.
//   The APB port sets max_line_length at byte address 0 (reset value 8000);
//   write it only while the block is idle.
//   Reset clears the line state, empties both registers and restores the limit.
`default_nettype none

module http_request_line_checker_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input byte channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  hrlc_pkg::t_in_item   i_in_data,
    // verdict channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output hrlc_pkg::t_out_item  o_out_data,
    // configuration port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [1:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import hrlc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic [15:0] r_max_len;

    logic      w_in_accept;
    logic      w_step;
    logic      w_can_load;
    logic      w_result_valid;
    t_out_item w_result;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_LINE_LENGTH) ? {16'b0, r_max_len} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LINE_LENGTH_RST;
        end else if (psel && penable && pwrite && paddr == REG_MAX_LINE_LENGTH) begin
            r_max_len <= pwdata[15:0];
        end
    end

    // the held item advances unless it closes a line and the result slot is busy
    assign w_step      = r_in_valid && (!r_in_data.end_of_line || w_can_load);
    assign o_in_stall  = r_in_valid && !w_step;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_accept || (r_in_valid && !w_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    hrlc_line_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_line_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_item         (r_in_data),
        .i_max_len      (r_max_len),
        .o_result_valid (w_result_valid),
        .o_result       (w_result)
    );

    hrlc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_result_valid),
        .i_data      (w_result),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
